// ===== rtl/core/sdspi_pkg.sv =====
// Package with shared types and constants for the SD card SPI host sequencer.
`default_nettype none
package sdspi_pkg;

    localparam int BLOCK_BYTES   = 512;
    localparam int R1_POLL_LIMIT = 10;
    localparam int WAKE_BYTES    = 10;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INIT_TRY   = 2'd0;
    localparam logic [1:0] CFG_READY_WAIT = 2'd1;
    localparam logic [1:0] CFG_TOKEN_WAIT = 2'd2;
    localparam logic [1:0] CFG_BUSY_WAIT  = 2'd3;

    // Operation codes.
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_READY  = 3'd1;
    localparam logic [2:0] ST_NO_IDLE    = 3'd2;
    localparam logic [2:0] ST_INIT_TMO   = 3'd3;
    localparam logic [2:0] ST_REJECTED   = 3'd4;
    localparam logic [2:0] ST_TOKEN_TMO  = 3'd5;
    localparam logic [2:0] ST_WR_REJECT  = 3'd6;
    localparam logic [2:0] ST_BUSY_TMO   = 3'd7;

    // Card commands.
    localparam logic [7:0] CMD_GO_IDLE  = 8'd0;
    localparam logic [7:0] CMD_IF_COND  = 8'd8;
    localparam logic [7:0] CMD_SET_LEN  = 8'd16;
    localparam logic [7:0] CMD_RD_SINGLE = 8'd17;
    localparam logic [7:0] CMD_WR_SINGLE = 8'd24;
    localparam logic [7:0] CMD_SD_OP    = 8'd41;
    localparam logic [7:0] CMD_APP      = 8'd55;
    localparam logic [7:0] CMD_READ_OCR = 8'd58;

    typedef struct packed {
        logic       kind;
        logic [1:0] op;
        logic [31:0] lba;
        logic [7:0] miso_byte;
        logic [7:0] write_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       chip_select_high;
        logic       exchange_request;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       write_taken;
        logic       done_res;
        logic [2:0] status;
        logic       high_capacity;
    } t_res;

endpackage
`default_nettype wire

// ===== rtl/core/sdspi_req_if.sv =====
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface sdspi_req_if;
    import sdspi_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdspi_res_if;
    import sdspi_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sd_card_spi_host_sequencer_unit.sv =====
// SD card SPI-mode host sequencer: top level.
//
// Each input transfer is either an operation request (kind 0: init, read
// block or write block) or the report of one finished SPI byte exchange
// (kind 1, carrying the received byte and the next byte to write).
// For every accepted input transfer the block produces exactly one result
// transfer: the next byte to send with the chip-select level, or done with
// a status, plus read data and a write-byte-consumed flag.
// The input is registered, then combinational sequencing feeds the result
// register; a result passes through both registers before it can be taken.
// One item is accepted per cycle unless both registers are occupied; the
// sequencer state updates in the same pass as the result register.
// Configuration is written through a plain write port; the user must write
// it only while idle, as the block itself does not enforce this.
// Reset (i_rst_n low, synchronous) returns to idle, deselects the card and
// restores the limit registers to their defaults.
// When the result receiver stalls, the result register holds and the input
// register fills; input ready drops only when both are occupied.
`default_nettype none
module sd_card_spi_host_sequencer_unit
    import sdspi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data,
    sdspi_req_if.sink        i_req,
    sdspi_res_if.source      o_res
);

    localparam logic [4:0] PH_IDLE = 5'd0, PH_WAKE = 5'd1, PH_DESEL = 5'd2,
        PH_READY = 5'd3, PH_FRAME = 5'd4, PH_R1 = 5'd5, PH_R7 = 5'd6,
        PH_OCR = 5'd7, PH_TOKEN = 5'd8, PH_RDATA = 5'd9, PH_RCRC = 5'd10,
        PH_WTOKEN = 5'd11, PH_WDATA = 5'd12, PH_WCRC = 5'd13,
        PH_WRESP = 5'd14, PH_BUSY = 5'd15, PH_FINAL = 5'd16;

    // Limit registers.
    logic [14:0] r_try_lim;
    logic [15:0] r_rdy_lim;
    logic [17:0] r_tok_lim;
    logic [19:0] r_busy_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_try_lim  <= 15'd20000;
            r_rdy_lim  <= 16'd50000;
            r_tok_lim  <= 18'd200000;
            r_busy_lim <= 20'd1000000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INIT_TRY:   r_try_lim  <= i_cfg_data[14:0];
                CFG_READY_WAIT: r_rdy_lim  <= i_cfg_data[15:0];
                CFG_TOKEN_WAIT: r_tok_lim  <= i_cfg_data[17:0];
                CFG_BUSY_WAIT:  r_busy_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register and result register handshake.
    logic r_in_v, r_out_v;
    t_req r_in;
    t_res r_out;
    logic step;

    assign step = r_in_v && (!r_out_v || o_res.ready);
    assign i_req.ready = !r_in_v || step;
    assign o_res.valid = r_out_v;
    assign o_res.data = r_out;

    // Sequencer state.
    logic [4:0]  r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [31:0] r_arg, n_arg;
    logic [2:0]  r_fidx, n_fidx;
    logic [19:0] r_poll, n_poll;
    logic [14:0] r_try, n_try;
    logic [9:0]  r_bidx, n_bidx;
    logic [7:0]  r_rb0, n_rb0, r_rb2, n_rb2, r_rb3, n_rb3;
    logic        r_v2, n_v2, r_blk, n_blk, r_crdy, n_crdy, r_cs, n_cs;
    logic [2:0]  r_fst, n_fst;
    logic [7:0]  r_r1, n_r1;
    t_res        res;

    logic [7:0]  fb;
    logic [2:0]  fi_next;
    logic [14:0] try_inc;
    logic [19:0] poll_inc;
    logic [9:0]  bidx_inc;
    logic [7:0]  m;

    // Frame byte for a given index of the pending command.
    function automatic logic [7:0] frame_byte(input logic [2:0] i, input logic [7:0] c,
                                              input logic [31:0] a);
        logic [7:0] b;
        case (i)
            3'd0: b = {2'b01, c[5:0]};
            3'd1: b = a[31:24];
            3'd2: b = a[23:16];
            3'd3: b = a[15:8];
            3'd4: b = a[7:0];
            default: b = (c == CMD_GO_IDLE) ? 8'h95 :
                         (c == CMD_IF_COND) ? 8'h87 : 8'h01;
        endcase
        return b;
    endfunction

    assign m = r_in.miso_byte;
    assign fi_next = r_fidx + 3'd1;
    assign try_inc = r_try + 15'd1;
    assign poll_inc = r_poll + 20'd1;
    assign bidx_inc = r_bidx + 10'd1;
    assign fb = frame_byte(fi_next, r_cmd, r_arg);

    always_comb begin
        n_phase = r_phase; n_cmd = r_cmd; n_arg = r_arg; n_fidx = r_fidx;
        n_poll = r_poll; n_try = r_try; n_bidx = r_bidx; n_rb0 = r_rb0;
        n_rb2 = r_rb2; n_rb3 = r_rb3; n_v2 = r_v2; n_blk = r_blk;
        n_crdy = r_crdy; n_cs = r_cs; n_fst = r_fst; n_r1 = r_r1;
        res = '0;
        res.mosi_byte = 8'hFF;
        res.chip_select_high = r_cs;

        // Common actions coded inline: emit, finish, start_command.
        if (!r_in.kind) begin
            if (r_phase == PH_IDLE) begin
                if (r_in.op == OP_INIT) begin
                    n_crdy = 1'b0; n_v2 = 1'b0; n_phase = PH_WAKE; n_bidx = '0;
                    res.exchange_request = 1'b1; res.chip_select_high = 1'b1;
                    n_cs = 1'b1;
                end else if (r_in.op != OP_READ && r_in.op != OP_WRITE) begin
                    res.done_res = 1'b1; res.status = ST_REJECTED;
                    res.chip_select_high = 1'b1; n_cs = 1'b1;
                end else if (!r_crdy) begin
                    res.done_res = 1'b1; res.status = ST_NOT_READY;
                    res.chip_select_high = 1'b1; n_cs = 1'b1;
                end else begin
                    n_cmd = (r_in.op == OP_READ) ? CMD_RD_SINGLE : CMD_WR_SINGLE;
                    n_arg = r_blk ? r_in.lba : {r_in.lba[22:0], 9'd0};
                    n_phase = PH_DESEL;
                    res.exchange_request = 1'b1; res.chip_select_high = 1'b1;
                    n_cs = 1'b1;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            // Default emit 0xFF with CS low; cases override.
            res.exchange_request = 1'b1;
            res.chip_select_high = 1'b0;
            n_cs = 1'b0;
            case (r_phase)
                PH_WAKE: begin
                    n_bidx = bidx_inc;
                    res.chip_select_high = 1'b1; n_cs = 1'b1;
                    if (bidx_inc >= 10'(WAKE_BYTES)) begin
                        n_cmd = CMD_GO_IDLE; n_arg = '0; n_phase = PH_DESEL;
                    end
                end
                PH_DESEL: begin
                    n_poll = '0;
                    if (r_rdy_lim == '0) begin
                        n_phase = PH_FRAME; n_fidx = '0;
                        res.mosi_byte = {2'b01, r_cmd[5:0]};
                    end else begin
                        n_phase = PH_READY;
                    end
                end
                PH_READY: begin
                    n_poll = poll_inc;
                    if (m == 8'hFF || poll_inc >= {4'd0, r_rdy_lim}) begin
                        n_phase = PH_FRAME; n_fidx = '0;
                        res.mosi_byte = {2'b01, r_cmd[5:0]};
                    end
                end
                PH_FRAME: begin
                    n_fidx = fi_next;
                    if (fi_next < 3'd6) begin
                        res.mosi_byte = fb;
                    end else begin
                        n_phase = PH_R1; n_poll = '0;
                    end
                end
                PH_R1: begin
                    n_poll = poll_inc;
                    if (!m[7] || poll_inc >= 20'(R1_POLL_LIMIT)) begin
                        n_r1 = m;
                        // Default for dispatch: start next command deselected.
                        res.chip_select_high = 1'b1; n_cs = 1'b1;
                        n_phase = PH_DESEL;
                        case (r_cmd)
                            CMD_GO_IDLE: begin
                                if (m != 8'h01) begin
                                    n_fst = ST_NO_IDLE; n_phase = PH_FINAL;
                                end else begin
                                    n_cmd = CMD_IF_COND; n_arg = 32'h1AA;
                                end
                            end
                            CMD_IF_COND: begin
                                if (m == 8'h01) begin
                                    n_phase = PH_R7; n_bidx = '0;
                                    res.chip_select_high = 1'b0; n_cs = 1'b0;
                                end else begin
                                    n_v2 = 1'b0; n_try = '0;
                                    if (r_try_lim == '0) begin
                                        n_fst = ST_INIT_TMO; n_phase = PH_FINAL;
                                    end else begin
                                        n_cmd = CMD_APP; n_arg = '0;
                                    end
                                end
                            end
                            CMD_APP: begin
                                n_cmd = CMD_SD_OP;
                                n_arg = r_v2 ? 32'h4000_0000 : 32'h0;
                            end
                            CMD_SD_OP: begin
                                if (m == 8'h00) begin
                                    if (r_v2) begin
                                        n_cmd = CMD_READ_OCR; n_arg = '0;
                                    end else begin
                                        n_blk = 1'b0; n_cmd = CMD_SET_LEN;
                                        n_arg = 32'(BLOCK_BYTES);
                                    end
                                end else begin
                                    n_try = try_inc;
                                    if (try_inc >= r_try_lim) begin
                                        n_fst = ST_INIT_TMO; n_phase = PH_FINAL;
                                    end else begin
                                        n_cmd = CMD_APP; n_arg = '0;
                                    end
                                end
                            end
                            CMD_READ_OCR: begin
                                n_phase = PH_OCR; n_bidx = '0;
                                res.chip_select_high = 1'b0; n_cs = 1'b0;
                            end
                            CMD_SET_LEN: begin
                                n_crdy = 1'b1; n_fst = ST_OK; n_phase = PH_FINAL;
                            end
                            CMD_RD_SINGLE: begin
                                if (m != 8'h00) begin
                                    n_fst = ST_REJECTED; n_phase = PH_FINAL;
                                end else if (r_tok_lim == '0) begin
                                    n_poll = '0;
                                    n_fst = ST_TOKEN_TMO; n_phase = PH_FINAL;
                                end else begin
                                    n_poll = '0; n_phase = PH_TOKEN;
                                    res.chip_select_high = 1'b0; n_cs = 1'b0;
                                end
                            end
                            CMD_WR_SINGLE: begin
                                if (m != 8'h00) begin
                                    n_fst = ST_REJECTED; n_phase = PH_FINAL;
                                end else begin
                                    n_phase = PH_WTOKEN; res.mosi_byte = 8'hFE;
                                    res.chip_select_high = 1'b0; n_cs = 1'b0;
                                end
                            end
                            default: begin
                                n_fst = ST_REJECTED; n_phase = PH_FINAL;
                            end
                        endcase
                    end
                end
                PH_R7, PH_OCR: begin
                    case (r_bidx[1:0])
                        2'd0: n_rb0 = m;
                        2'd2: n_rb2 = m;
                        2'd3: n_rb3 = m;
                        default: ;
                    endcase
                    n_bidx = bidx_inc;
                    if (bidx_inc >= 10'd4) begin
                        res.chip_select_high = 1'b1; n_cs = 1'b1;
                        if (r_phase == PH_R7) begin
                            n_v2 = (r_rb2 == 8'h01) && (m == 8'hAA);
                            n_try = '0;
                            if (r_try_lim == '0) begin
                                n_fst = ST_INIT_TMO; n_phase = PH_FINAL;
                            end else begin
                                n_cmd = CMD_APP; n_arg = '0; n_phase = PH_DESEL;
                            end
                        end else begin
                            if (r_r1 == 8'h00) n_blk = r_rb0[6];
                            n_crdy = 1'b1; n_fst = ST_OK; n_phase = PH_FINAL;
                        end
                    end
                end
                PH_TOKEN: begin
                    if (m == 8'hFE) begin
                        n_phase = PH_RDATA; n_bidx = '0;
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= {2'd0, r_tok_lim}) begin
                            n_fst = ST_TOKEN_TMO; n_phase = PH_FINAL;
                            res.chip_select_high = 1'b1; n_cs = 1'b1;
                        end
                    end
                end
                PH_RDATA: begin
                    res.read_byte = m; res.read_valid = 1'b1;
                    n_bidx = bidx_inc;
                    if (bidx_inc >= 10'(BLOCK_BYTES - 1) + 10'd1 || bidx_inc == '0) begin
                        n_phase = PH_RCRC; n_bidx = '0;
                    end
                end
                PH_RCRC: begin
                    n_bidx = bidx_inc;
                    if (bidx_inc >= 10'd2) begin
                        n_fst = ST_OK; n_phase = PH_FINAL;
                        res.chip_select_high = 1'b1; n_cs = 1'b1;
                    end
                end
                PH_WTOKEN: begin
                    n_phase = PH_WDATA; n_bidx = '0;
                    res.mosi_byte = r_in.write_byte; res.write_taken = 1'b1;
                end
                PH_WDATA: begin
                    n_bidx = bidx_inc;
                    if (bidx_inc >= 10'(BLOCK_BYTES)) begin
                        n_phase = PH_WCRC; n_bidx = '0;
                    end else begin
                        res.mosi_byte = r_in.write_byte; res.write_taken = 1'b1;
                    end
                end
                PH_WCRC: begin
                    n_bidx = bidx_inc;
                    if (bidx_inc >= 10'd2) n_phase = PH_WRESP;
                end
                PH_WRESP: begin
                    if (m[4:0] != 5'h05) begin
                        n_fst = ST_WR_REJECT; n_phase = PH_FINAL;
                        res.chip_select_high = 1'b1; n_cs = 1'b1;
                    end else begin
                        n_poll = '0; n_phase = PH_BUSY;
                        if (r_busy_lim == '0) begin
                            n_fst = ST_BUSY_TMO; n_phase = PH_FINAL;
                            res.chip_select_high = 1'b1; n_cs = 1'b1;
                        end
                    end
                end
                PH_BUSY: begin
                    if (m == 8'hFF) begin
                        n_fst = ST_OK; n_phase = PH_FINAL;
                        res.chip_select_high = 1'b1; n_cs = 1'b1;
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= r_busy_lim) begin
                            n_fst = ST_BUSY_TMO; n_phase = PH_FINAL;
                            res.chip_select_high = 1'b1; n_cs = 1'b1;
                        end
                    end
                end
                PH_FINAL: begin
                    res.exchange_request = 1'b0;
                    res.mosi_byte = 8'hFF;
                    res.done_res = 1'b1; res.status = r_fst;
                    res.chip_select_high = 1'b1; n_cs = 1'b1;
                    n_phase = PH_IDLE;
                end
                default: begin
                    res.exchange_request = 1'b0;
                    res.chip_select_high = r_cs; n_cs = r_cs;
                end
            endcase
        end
        res.high_capacity = n_blk;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0; r_out_v <= 1'b0;
            r_phase <= PH_IDLE; r_cmd <= '0; r_arg <= '0; r_fidx <= '0;
            r_poll <= '0; r_try <= '0; r_bidx <= '0; r_rb0 <= '0; r_rb2 <= '0;
            r_rb3 <= '0; r_v2 <= 1'b0; r_blk <= 1'b0; r_crdy <= 1'b0;
            r_cs <= 1'b1; r_fst <= '0; r_r1 <= '0;
        end else begin
            if (i_req.ready) r_in_v <= i_req.valid;
            if (step) r_out_v <= 1'b1;
            else if (o_res.ready) r_out_v <= 1'b0;
            if (step) begin
                r_phase <= n_phase; r_cmd <= n_cmd; r_arg <= n_arg;
                r_fidx <= n_fidx; r_poll <= n_poll; r_try <= n_try;
                r_bidx <= n_bidx; r_rb0 <= n_rb0; r_rb2 <= n_rb2; r_rb3 <= n_rb3;
                r_v2 <= n_v2; r_blk <= n_blk; r_crdy <= n_crdy; r_cs <= n_cs;
                r_fst <= n_fst; r_r1 <= n_r1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) r_in <= i_req.data;
        if (step) r_out <= res;
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !o_res.ready |=> r_out_v && $stable(r_out))
        else $error("result changed while stalled");
    a_done_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.done_res |-> r_out.chip_select_high && !r_out.exchange_request)
        else $error("done with card selected");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && res.done_res |=> r_phase == PH_IDLE)
        else $error("done without returning to idle");
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_out.read_valid && r_out.write_taken))
        else $error("read and write flags together");
`endif

endmodule
`default_nettype wire
